>>> hw/rtl/zpfla_pkg.sv
package zpfla_pkg;

  // default sizing
  localparam int unsigned NumPagesDef  = 4096;
  localparam int unsigned PageBytesDef = 4096;

  // fixed field widths
  localparam int unsigned AddrW    = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned ZoneW    = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 13;
  localparam int unsigned PageRegW = 13;
  localparam int unsigned UseW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // configuration reset values
  localparam logic [AddrW-1:0]    VBaseRst    = 32'hC000_0000;
  localparam logic [PageRegW-1:0] DmaLimitRst = 13'd2048;
  localparam logic [PageRegW-1:0] ReservedRst = 13'd256;
  localparam logic [PageRegW-1:0] EndPageRst  = 13'd4096;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [ZoneW-1:0] {
    ZONE_DMA = 2'd0,
    ZONE_NRM = 2'd1
  } zone_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NOZONE  = 3'd2,
    ST_IGNORED = 3'd3,
    ST_RANGE   = 3'd4,
    ST_ZERO    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VBASE     = 2'd0,
    CFG_DMA_LIMIT = 2'd1,
    CFG_RESERVED  = 2'd2,
    CFG_END_PAGE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_INIT = 2'd1,
    S_EXEC = 2'd2
  } state_e;

endpackage

>>> hw/rtl/zpfla_if.sv
// request channel
interface zpfla_req_if import zpfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [ZoneW-1:0] alloc_zone;
  logic [AddrW-1:0] address;

  modport source (output valid, output operation, output alloc_zone, output address,
                  input ready);
  modport sink (input valid, input operation, input alloc_zone, input address,
                output ready);
endinterface

// response channel
interface zpfla_rsp_if import zpfla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AddrW-1:0]   page_address;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  dma_free_pages;
  logic [CountW-1:0]  normal_free_pages;

  modport source (output valid, output page_address, output status,
                  output dma_free_pages, output normal_free_pages, input ready);
  modport sink (input valid, input page_address, input status,
                input dma_free_pages, input normal_free_pages, output ready);
endinterface

>>> hw/rtl/zoned_page_free_list_allocator.sv
// Page frame allocator with a DMA free list and a normal free list, both LIFO
// stacks threaded through a per-page link/use-count memory.
// Request channel in_i: operation (allocate, free, initialize), alloc_zone for
// allocate, address for free. Response channel out_o: one transfer per request
// with page_address, status and both free list lengths after the request.
// Configuration (virtual base, DMA limit, reserved pages, end page) is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while
// the block is idle; the block itself does not enforce this. Allocate, free
// and unknown requests make a single read-then-write pass over the page memory:
// the accept cycle reads it, the write-back state modifies and writes it back
// and loads the response register. Initialize makes one page memory write per
// page, then passes the write-back state; one request is in flight at a time.
// The response sits in an output register; a new request is taken while it
// waits, but the write-back cycle holds until the output register is free.
// Reset clears the lists (both empty) and loads the configuration defaults;
// page memory contents are undefined until an initialize request.
module zoned_page_free_list_allocator import zpfla_pkg::*; #(
  parameter int unsigned NUM_PAGES  = NumPagesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  zpfla_req_if.sink           in_i,
  zpfla_rsp_if.source         out_o
);

  localparam int unsigned PW   = $clog2(NUM_PAGES);
  localparam int unsigned LW   = $clog2(NUM_PAGES + 1);
  localparam int unsigned OffW = $clog2(PAGE_BYTES);
  localparam int unsigned PgW  = AddrW - OffW;
  localparam int unsigned MW   = PW + UseW;

  // configuration registers
  logic [AddrW-1:0]    vbase_q;
  logic [PageRegW-1:0] dma_limit_q, reserved_q, end_page_q;

  // control state
  state_e              state_q, state_d;
  logic [PW-1:0]       dma_head_q, dma_head_d, normal_head_q, normal_head_d;
  logic [CountW-1:0]   dma_count_q, dma_count_d, normal_count_q, normal_count_d;
  logic [PW-1:0]       sweep_q, sweep_d;
  logic                out_valid_q;

  // latched request
  logic [OpW-1:0]      op_q;
  logic [ZoneW-1:0]    zone_q;
  logic [PgW-1:0]      pg_q;
  logic                addr_zero_q;

  // response payload
  logic [AddrW-1:0]    rsp_addr_q, rsp_addr;
  logic [StatusW-1:0]  rsp_status_q;
  status_e             rsp_status;
  logic [CountW-1:0]   rsp_dma_q, rsp_normal_q;

  // page memory: {link, use count}
  logic [MW-1:0]       page_mem [NUM_PAGES];
  logic [MW-1:0]       rd_data_q;
  logic                mem_we;
  logic [PW-1:0]       mem_waddr, mem_raddr;
  logic [MW-1:0]       mem_wdata;

  logic                in_xfer, exec_fire, sweep_last;
  logic [AddrW-1:0]    in_phys;
  logic [PgW-1:0]      in_pg;
  logic [PW-1:0]       pg_idx, pg_sel;
  logic [LW-1:0]       dma_lim, res_lim, end_lim;
  logic [PW-1:0]       rd_link;
  logic [UseW-1:0]     rd_cnt;

  function automatic logic [LW-1:0] clamp_pages(input logic [PageRegW-1:0] v);
    if (32'(v) > NUM_PAGES) begin
      return LW'(NUM_PAGES);
    end
    return LW'(v);
  endfunction

  assign dma_lim = clamp_pages(dma_limit_q);
  assign res_lim = clamp_pages(reserved_q);
  assign end_lim = clamp_pages(end_page_q);

  // handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign exec_fire  = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign sweep_last = (sweep_q == PW'(NUM_PAGES - 1));

  // page number of the freed address
  assign in_phys = in_i.address - vbase_q;
  assign in_pg   = in_phys[AddrW-1:OffW];
  assign pg_idx  = PW'(pg_q);

  assign rd_link = rd_data_q[MW-1:UseW];
  assign rd_cnt  = rd_data_q[UseW-1:0];

  // read address chosen at accept
  always_comb begin
    if (in_i.operation == OP_FREE) begin
      mem_raddr = PW'(in_pg);
    end else if (in_i.alloc_zone == ZONE_NRM) begin
      mem_raddr = normal_head_q;
    end else begin
      mem_raddr = dma_head_q;
    end
  end

  // page memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      page_mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rd_data_q <= page_mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (in_i.operation == OP_INIT) ? S_INIT : S_EXEC;
        end
      end
      S_INIT: begin
        if (sweep_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // list updates, memory write-back and response
  always_comb begin
    dma_head_d     = dma_head_q;
    normal_head_d  = normal_head_q;
    dma_count_d    = dma_count_q;
    normal_count_d = normal_count_q;
    sweep_d        = sweep_q;
    mem_we         = 1'b0;
    mem_waddr      = sweep_q;
    mem_wdata      = '0;
    rsp_status     = ST_OK;
    rsp_addr       = '0;
    pg_sel         = dma_head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && in_i.operation == OP_INIT) begin
          dma_head_d     = '0;
          normal_head_d  = '0;
          dma_count_d    = '0;
          normal_count_d = '0;
          sweep_d        = '0;
        end
      end

      // one page per cycle, ascending
      S_INIT: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + PW'(1);
        if (32'(sweep_q) < 32'(res_lim)) begin
          mem_wdata = {PW'(0), UseW'(1)};
        end else if (32'(sweep_q) < 32'(end_lim)) begin
          if (32'(sweep_q) < 32'(dma_lim)) begin
            mem_wdata   = {dma_head_q, UseW'(0)};
            dma_head_d  = sweep_q;
            dma_count_d = dma_count_q + CountW'(1);
          end else begin
            mem_wdata      = {normal_head_q, UseW'(0)};
            normal_head_d  = sweep_q;
            normal_count_d = normal_count_q + CountW'(1);
          end
        end
      end

      S_EXEC: begin
        unique case (op_q)
          OP_ALLOC: begin
            if (zone_q == ZONE_DMA || zone_q == ZONE_NRM) begin
              if (zone_q == ZONE_DMA) begin
                pg_sel = dma_head_q;
              end else begin
                pg_sel = normal_head_q;
              end
              if ((zone_q == ZONE_DMA && dma_count_q == '0) ||
                  (zone_q == ZONE_NRM && normal_count_q == '0)) begin
                rsp_status = ST_EMPTY;
              end else begin
                if (zone_q == ZONE_DMA) begin
                  dma_head_d  = rd_link;
                  dma_count_d = dma_count_q - CountW'(1);
                end else begin
                  normal_head_d  = rd_link;
                  normal_count_d = normal_count_q - CountW'(1);
                end
                mem_we    = 1'b1;
                mem_waddr = pg_sel;
                mem_wdata = {rd_link, (rd_cnt == '1) ? rd_cnt : rd_cnt + UseW'(1)};
                rsp_addr  = (AddrW'(pg_sel) << OffW) + vbase_q;
              end
            end else begin
              rsp_status = ST_NOZONE;
            end
          end

          OP_FREE: begin
            mem_waddr = pg_idx;
            priority if (addr_zero_q) begin
              rsp_status = ST_IGNORED;
            end else if (32'(pg_q) < 32'(res_lim)) begin
              rsp_status = ST_IGNORED;
            end else if (32'(pg_q) >= 32'(end_lim)) begin
              rsp_status = ST_RANGE;
            end else if (rd_cnt == '0) begin
              rsp_status = ST_ZERO;
            end else begin
              mem_we = 1'b1;
              if (rd_cnt == UseW'(1)) begin
                // last holder gone: push onto its zone
                if (32'(pg_q) < 32'(dma_lim)) begin
                  mem_wdata   = {dma_head_q, UseW'(0)};
                  dma_head_d  = pg_idx;
                  dma_count_d = dma_count_q + CountW'(1);
                end else begin
                  mem_wdata      = {normal_head_q, UseW'(0)};
                  normal_head_d  = pg_idx;
                  normal_count_d = normal_count_q + CountW'(1);
                end
              end else begin
                mem_wdata = {rd_link, rd_cnt - UseW'(1)};
              end
            end
          end

          OP_INIT: rsp_status = ST_OK;

          default: rsp_status = ST_IGNORED;
        endcase

        // hold everything while the response register is occupied
        if (!exec_fire) begin
          mem_we         = 1'b0;
          dma_head_d     = dma_head_q;
          normal_head_d  = normal_head_q;
          dma_count_d    = dma_count_q;
          normal_count_d = normal_count_q;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      dma_head_q     <= '0;
      normal_head_q  <= '0;
      dma_count_q    <= '0;
      normal_count_q <= '0;
      sweep_q        <= '0;
      out_valid_q    <= 1'b0;
      vbase_q        <= VBaseRst;
      dma_limit_q    <= DmaLimitRst;
      reserved_q     <= ReservedRst;
      end_page_q     <= EndPageRst;
    end else begin
      state_q        <= state_d;
      dma_head_q     <= dma_head_d;
      normal_head_q  <= normal_head_d;
      dma_count_q    <= dma_count_d;
      normal_count_q <= normal_count_d;
      sweep_q        <= sweep_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VBASE:     vbase_q     <= cfg_data_i;
          CFG_DMA_LIMIT: dma_limit_q <= cfg_data_i[PageRegW-1:0];
          CFG_RESERVED:  reserved_q  <= cfg_data_i[PageRegW-1:0];
          CFG_END_PAGE:  end_page_q  <= cfg_data_i[PageRegW-1:0];
        endcase
      end
    end
  end

  // request and response payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= in_i.operation;
      zone_q      <= in_i.alloc_zone;
      pg_q        <= in_pg;
      addr_zero_q <= (in_i.address == '0);
    end
    if (exec_fire) begin
      rsp_addr_q   <= rsp_addr;
      rsp_status_q <= rsp_status;
      rsp_dma_q    <= dma_count_d;
      rsp_normal_q <= normal_count_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.page_address      = rsp_addr_q;
  assign out_o.status            = rsp_status_q;
  assign out_o.dma_free_pages    = rsp_dma_q;
  assign out_o.normal_free_pages = rsp_normal_q;

  // a request transfer always starts the memory pass
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EXEC || state_q == S_INIT))
    else $error("request transfer did not start work");

  // a response only appears out of the write-back cycle
  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EXEC)
    else $error("response raised outside write-back");

  // page memory is only written while busy
  a_mem_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EXEC || state_q == S_INIT))
    else $error("page memory written while idle");

  // initialize starts from empty lists
  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.operation == OP_INIT) |=> (dma_count_q == '0 && normal_count_q == '0))
    else $error("lists not emptied at initialize");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import zpfla_pkg::*;

  localparam int unsigned NumPages     = NumPagesDef;
  localparam int unsigned PageBytes    = PageBytesDef;
  localparam int unsigned PageW        = $clog2(NumPages);
  localparam int unsigned StallPct     = 18;
  localparam int unsigned IdleLimit    = 20000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 20;

  // codes outside the package enums
  localparam logic [OpW-1:0]   OP_UNKNOWN   = 2'd3;
  localparam logic [ZoneW-1:0] ZONE_NONE    = 2'd2;
  localparam logic [ZoneW-1:0] ZONE_NONE_HI = 2'd3;

  typedef struct {
    logic [OpW-1:0]   operation;
    logic [ZoneW-1:0] alloc_zone;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct {
    logic [AddrW-1:0]   page_address;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  dma_free_pages;
    logic [CountW-1:0]  normal_free_pages;
  } rsp_t;

  // mirror of both free lists and per-page use counts, plus awaited responses
  class frame_accounting;
    logic [AddrW-1:0]    vbase;
    logic [PageRegW-1:0] dma_limit;
    logic [PageRegW-1:0] reserved;
    logic [PageRegW-1:0] end_pg;
    logic [PageW-1:0]    next_link [NumPages];
    logic [UseW-1:0]     holds [NumPages];
    logic [PageW-1:0]    dma_top;
    logic [PageW-1:0]    normal_top;
    logic [CountW-1:0]   dma_len;
    logic [CountW-1:0]   normal_len;
    rsp_t                awaited_rsp [$];
    int unsigned         mismatches;

    function new();
      vbase      = VBaseRst;
      dma_limit  = DmaLimitRst;
      reserved   = ReservedRst;
      end_pg     = EndPageRst;
      dma_top    = '0;
      normal_top = '0;
      dma_len    = '0;
      normal_len = '0;
      mismatches = 0;
    endfunction

    // page-number registers saturate at the memory size
    function int unsigned clamp_pg(logic [PageRegW-1:0] v);
      return (v > NumPages) ? NumPages : int'(v);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_VBASE:     vbase     = data;
        CFG_DMA_LIMIT: dma_limit = data[PageRegW-1:0];
        CFG_RESERVED:  reserved  = data[PageRegW-1:0];
        CFG_END_PAGE:  end_pg    = data[PageRegW-1:0];
        default: ;
      endcase
    endfunction

    // push a page onto the list of its zone
    function void list_frame(int unsigned pg);
      if (pg < clamp_pg(dma_limit)) begin
        next_link[pg] = dma_top;
        dma_top = PageW'(pg);
        dma_len++;
      end else begin
        next_link[pg] = normal_top;
        normal_top = PageW'(pg);
        normal_len++;
      end
    endfunction

    // work out the response of one accepted request and queue it
    function rsp_t log_request(req_t r);
      rsp_t             e;
      int unsigned      pg;
      logic [AddrW-1:0] phys;
      e.page_address = '0;
      e.status       = ST_OK;
      pg             = 0;
      case (r.operation)
        OP_ALLOC: begin
          if (r.alloc_zone != ZONE_DMA && r.alloc_zone != ZONE_NRM) begin
            e.status = ST_NOZONE;
          end else if (r.alloc_zone == ZONE_DMA) begin
            if (dma_len == 0) begin
              e.status = ST_EMPTY;
            end else begin
              pg = dma_top;
              dma_top = next_link[pg];
              dma_len--;
            end
          end else begin
            if (normal_len == 0) begin
              e.status = ST_EMPTY;
            end else begin
              pg = normal_top;
              normal_top = next_link[pg];
              normal_len--;
            end
          end
          if (e.status == ST_OK) begin
            if (holds[pg] != '1) holds[pg]++;
            e.page_address = vbase + AddrW'(pg * PageBytes);
          end
        end
        OP_FREE: begin
          phys = r.address - vbase;
          pg = phys / PageBytes;
          if (r.address == '0 || pg < clamp_pg(reserved)) begin
            e.status = ST_IGNORED;
          end else if (pg >= clamp_pg(end_pg)) begin
            e.status = ST_RANGE;
          end else if (holds[pg] == '0) begin
            e.status = ST_ZERO;
          end else begin
            holds[pg]--;
            if (holds[pg] == '0) list_frame(pg);
          end
        end
        OP_INIT: begin
          dma_top    = '0;
          normal_top = '0;
          dma_len    = '0;
          normal_len = '0;
          for (int unsigned p = 0; p < NumPages; p++) begin
            if (p < clamp_pg(reserved)) begin
              holds[p] = 1;
            end else begin
              holds[p] = '0;
              if (p < clamp_pg(end_pg)) list_frame(p);
            end
          end
        end
        default: e.status = ST_IGNORED;
      endcase
      e.dma_free_pages    = dma_len;
      e.normal_free_pages = normal_len;
      awaited_rsp.push_back(e);
      return e;
    endfunction

    // compare one response transfer against the oldest awaited one
    function void match_response(rsp_t got);
      rsp_t e;
      if (awaited_rsp.size() == 0) begin
        $error("response with nothing awaited: page_address %h status %0d",
               got.page_address, got.status);
        mismatches++;
        return;
      end
      e = awaited_rsp.pop_front();
      if (got.page_address !== e.page_address) begin
        $error("page_address: expected %h, actual %h", e.page_address, got.page_address);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        mismatches++;
      end
      if (got.dma_free_pages !== e.dma_free_pages) begin
        $error("dma_free_pages: expected %0d, actual %0d",
               e.dma_free_pages, got.dma_free_pages);
        mismatches++;
      end
      if (got.normal_free_pages !== e.normal_free_pages) begin
        $error("normal_free_pages: expected %0d, actual %0d",
               e.normal_free_pages, got.normal_free_pages);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  bit                  stall_en = 1'b1;
  int unsigned         quiet_cycles = 0;
  int unsigned         held_pg [$];
  int unsigned         freed_pg [$];
  frame_accounting     acct;

  zpfla_req_if req ();
  zpfla_rsp_if rsp ();

  zoned_page_free_list_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req),
    .out_o      (rsp)
  );

  always #1 clk_i = ~clk_i;

  // response side back-pressure
  always @(negedge clk_i) begin
    rsp.ready <= !stall_en || ($urandom_range(99) >= StallPct);
  end

  // response check
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      acct.match_response('{rsp.page_address, rsp.status,
                            rsp.dma_free_pages, rsp.normal_free_pages});
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [AddrW-1:0] frame_addr(int unsigned pg);
    return acct.vbase + AddrW'(pg * PageBytes);
  endfunction

  // drive one request and wait for its transfer
  task automatic send(input logic [OpW-1:0] op, input logic [ZoneW-1:0] zone,
                      input logic [AddrW-1:0] addr);
    req_t r;
    rsp_t e;
    r.operation  = op;
    r.alloc_zone = zone;
    r.address    = addr;
    while (stall_en && $urandom_range(99) < StallPct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.alloc_zone <= zone;
    req.address    <= addr;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    e = acct.log_request(r);
    if (op == OP_ALLOC && e.status == ST_OK) begin
      held_pg.push_back((e.page_address - acct.vbase) / PageBytes);
    end
    if (op == OP_INIT) begin
      held_pg.delete();
      freed_pg.delete();
    end
    @(negedge clk_i);
  endtask

  // stop sending until every response has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (acct.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    acct.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [AddrW-1:0] vb, input int unsigned dma,
                           input int unsigned res, input int unsigned endp,
                           input bit reinit, input int unsigned items);
    wait_drained();
    write_reg(CFG_VBASE, vb);
    write_reg(CFG_DMA_LIMIT, CfgDataW'(dma));
    write_reg(CFG_RESERVED, CfgDataW'(res));
    write_reg(CFG_END_PAGE, CfgDataW'(endp));
    cfg_we_i <= 1'b0;
    if (reinit) send(OP_INIT, ZONE_NONE, '0);
    repeat (items) random_item();
  endtask

  // mostly alloc/free pairs on real pages, with stray and malformed requests
  task automatic random_item();
    int unsigned      roll;
    int unsigned      zr;
    int unsigned      idx;
    int unsigned      pg;
    int unsigned      res;
    int unsigned      endp;
    logic [ZoneW-1:0] zone;
    roll = $urandom_range(99);
    zr   = $urandom_range(99);
    res  = acct.clamp_pg(acct.reserved);
    endp = acct.clamp_pg(acct.end_pg);
    zone = (zr < 45) ? ZONE_DMA : (zr < 90) ? ZONE_NRM :
           (zr < 95) ? ZONE_NONE : ZONE_NONE_HI;
    if (roll < 38 || (roll < 70 && held_pg.size() == 0)) begin
      send(OP_ALLOC, zone, $urandom());
    end else if (roll < 70) begin
      idx = $urandom_range(held_pg.size() - 1);
      pg = held_pg[idx];
      held_pg.delete(idx);
      freed_pg.push_back(pg);
      if (freed_pg.size() > 8) void'(freed_pg.pop_front());
      send(OP_FREE, zone, frame_addr(pg) + AddrW'($urandom_range(PageBytes - 1)));
    end else if (roll < 75 && freed_pg.size() != 0) begin
      send(OP_FREE, zone, frame_addr(freed_pg[$urandom_range(freed_pg.size() - 1)]));
    end else if (roll < 80) begin
      send(OP_FREE, zone, $urandom());
    end else if (roll < 84) begin
      send(OP_FREE, zone, frame_addr($urandom_range(res)));
    end else if (roll < 88) begin
      send(OP_FREE, zone, frame_addr(endp + $urandom_range(64)));
    end else if (roll < 91) begin
      send(OP_FREE, zone, '0);
    end else if (roll < 94) begin
      send(OP_UNKNOWN, zone, $urandom());
    end else if (roll < 95) begin
      send(OP_INIT, zone, $urandom());
    end else if (roll < 96) begin
      wait_drained();
    end else begin
      send(OP_FREE, zone, frame_addr($urandom_range(NumPages - 1)));
    end
  endtask

  initial begin
    logic [AddrW-1:0] vb;
    acct           = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_VBASE;
    cfg_data_i     = '0;
    req.valid      = 1'b0;
    req.operation  = OP_ALLOC;
    req.alloc_zone = ZONE_DMA;
    req.address    = '0;
    rsp.ready      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty lists before init, then each status at reset settings
    send(OP_ALLOC, ZONE_DMA, '0);
    send(OP_ALLOC, ZONE_NRM, '1);
    send(OP_ALLOC, ZONE_NONE, '0);
    send(OP_UNKNOWN, ZONE_NONE_HI, '1);
    send(OP_INIT, ZONE_DMA, '0);
    send(OP_ALLOC, ZONE_DMA, '0);
    send(OP_ALLOC, ZONE_NRM, '0);
    send(OP_ALLOC, ZONE_NONE_HI, '0);
    send(OP_FREE, ZONE_DMA, frame_addr(DmaLimitRst - 1));
    send(OP_FREE, ZONE_DMA, frame_addr(DmaLimitRst - 1));
    send(OP_FREE, ZONE_DMA, '0);
    send(OP_FREE, ZONE_DMA, frame_addr(0));
    send(OP_FREE, ZONE_DMA, frame_addr(ReservedRst - 1) + AddrW'(PageBytes - 1));
    send(OP_FREE, ZONE_DMA, frame_addr(ReservedRst));
    send(OP_FREE, ZONE_DMA, frame_addr(NumPages));
    send(OP_FREE, ZONE_DMA, '1);
    send(OP_FREE, ZONE_DMA, AddrW'(PageBytes));
    send(OP_FREE, ZONE_NRM, frame_addr(NumPages - 1) + AddrW'(1));
    send(OP_ALLOC, ZONE_NRM, '0);
    send(OP_UNKNOWN, ZONE_DMA, '0);

    // fixed settings, extremes included
    run_phase(32'h0000_0000, 4, 2, 12, 1'b1, 200);
    run_phase(32'hFFFF_F000, 0, 0, 4096, 1'b1, 200);
    run_phase(32'hC000_0000, 4096, 4096, 4096, 1'b1, 60);
    run_phase(32'h8000_0000, 8191, 0, 16, 1'b1, 200);
    // zone boundary moved under live lists
    run_phase(32'h8000_0000, 6, 1, 8191, 1'b0, 150);
    run_phase(32'h1234_5000, 8, 3, 0, 1'b1, 100);
    // back-to-back stretch with no stalls on either side
    stall_en = 1'b0;
    run_phase(32'h4000_0000, 2048, 256, 4096, 1'b1, 250);
    stall_en = 1'b1;
    // small random maps so lists run dry and refill
    repeat (5) begin
      vb = $urandom();
      vb[11:0] = '0;
      run_phase(vb, $urandom_range(40), $urandom_range(16), $urandom_range(64), 1'b1, 150);
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (acct.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
